/* sv/rtuchk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rtuchk_pkg;

	localparam int MAX_FRAME_DEF = 256;
	localparam int MIN_FRAME_DEF = 5;

	localparam int HDR_BYTES = 6;
	localparam int HDR_IDX_W = 3;
	localparam int COUNT_W   = 9;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int IN_DW     = 8;
	localparam int OUT_DW    = 88;

	localparam logic [COUNT_W-1:0] COUNT_SAT = 9'd511;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] COIL_ON     = 16'hFF00;
	localparam logic [15:0] COIL_OFF    = 16'h0000;
	localparam logic [7:0]  FC_EXC_FLAG = 8'h80;

	// register indexes
	localparam logic [2:0] REG_OWN_ADDR  = 3'd0;
	localparam logic [2:0] REG_REG_MIN   = 3'd1;
	localparam logic [2:0] REG_REG_MAX   = 3'd2;
	localparam logic [2:0] REG_COIL_MIN  = 3'd3;
	localparam logic [2:0] REG_COIL_MAX  = 3'd4;

	localparam logic [7:0]  DEF_OWN_ADDR = 8'd1;
	localparam logic [15:0] DEF_REG_MIN  = 16'd1;
	localparam logic [15:0] DEF_REG_MAX  = 16'd125;
	localparam logic [15:0] DEF_COIL_MIN = 16'd1;
	localparam logic [15:0] DEF_COIL_MAX = 16'd2000;

	// function codes
	localparam logic [7:0] FC_READ_COILS  = 8'd1;
	localparam logic [7:0] FC_READ_REGS   = 8'd3;
	localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
	localparam logic [7:0] FC_WRITE_REG   = 8'd6;
	localparam logic [7:0] FC_WRITE_REGS  = 8'd16;

	// outcome codes
	localparam logic [2:0] OUT_OK        = 3'd0;
	localparam logic [2:0] OUT_NOT_ADDR  = 3'd1;
	localparam logic [2:0] OUT_BAD_FRAME = 3'd2;
	localparam logic [2:0] OUT_ILL_FUNC  = 3'd3;
	localparam logic [2:0] OUT_ILL_DATA  = 3'd4;

	// exception codes
	localparam logic [1:0] EXC_NONE      = 2'd0;
	localparam logic [1:0] EXC_ILL_FUNC  = 2'd1;
	localparam logic [1:0] EXC_ILL_DATA  = 2'd3;

	typedef struct packed {
		logic [7:0]  own_address;
		logic [15:0] reg_count_min;
		logic [15:0] reg_count_max;
		logic [15:0] coil_count_min;
		logic [15:0] coil_count_max;
	} cfg_t;

	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] hdr;
		logic [15:0]               crc;
		logic [COUNT_W-1:0]        count;
	} frame_t;

	// first member sits in the highest bits
	typedef struct packed {
		logic [2:0]  pad;
		logic [15:0] reply_crc;
		logic [1:0]  exception_code;
		logic [15:0] write_value;
		logic [15:0] data_count;
		logic [15:0] data_addr;
		logic [7:0]  function_code;
		logic [7:0]  slave_addr;
		logic [2:0]  outcome;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/modbus_rtu_slave_request_checker_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// the last byte of a frame is registered in the frame-end register, then judged into the output register
// throughput: one byte per cycle, frames back to back, while the output takes verdicts; set by the byte-wide crc update
// the output register and the frame-end register let input run while a verdict waits
// reset: arst_n asynchronous active low; crc, byte count, header and valids clear,
// registers return to own_address 1, reg counts 1..125, coil counts 1..2000
module modbus_rtu_slave_request_checker_core #(
	parameter int MAX_FRAME = rtuchk_pkg::MAX_FRAME_DEF,
	parameter int MIN_FRAME = rtuchk_pkg::MIN_FRAME_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [rtuchk_pkg::IN_DW-1:0]  s_tdata,  // [7:0] rx_byte
	input  wire logic                          s_tlast,  // frame_end
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [2:0] outcome, [10:3] slave_addr, [18:11] function_code, [34:19] data_addr,
	// [50:35] data_count, [66:51] write_value, [68:67] exception_code,
	// [84:69] reply_crc, [87:85] zero
	output logic      [rtuchk_pkg::OUT_DW-1:0] m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rtuchk_pkg::APB_AW-1:0] paddr,
	input  wire logic [rtuchk_pkg::APB_DW-1:0] pwdata,
	output logic      [rtuchk_pkg::APB_DW-1:0] prdata,
	output logic                               pready
);
	import rtuchk_pkg::*;

	cfg_t   cfg;
	frame_t frame;
	logic   frame_valid;
	logic   pop;

	rtuchk_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtuchk_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

	rtuchk_check #(
		.MAX_FRAME (MAX_FRAME),
		.MIN_FRAME (MIN_FRAME)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.frame_valid (frame_valid),
		.frame       (frame),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule
`default_nettype wire

/* sv/rtuchk_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtuchk_cfg_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [rtuchk_pkg::APB_AW-1:0] paddr,
	input  wire logic [rtuchk_pkg::APB_DW-1:0] pwdata,
	output logic      [rtuchk_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output rtuchk_pkg::cfg_t                cfg
);
	import rtuchk_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address    <= DEF_OWN_ADDR;
			cfg_q.reg_count_min  <= DEF_REG_MIN;
			cfg_q.reg_count_max  <= DEF_REG_MAX;
			cfg_q.coil_count_min <= DEF_COIL_MIN;
			cfg_q.coil_count_max <= DEF_COIL_MAX;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OWN_ADDR: cfg_q.own_address    <= pwdata[7:0];
				REG_REG_MIN:  cfg_q.reg_count_min  <= pwdata[15:0];
				REG_REG_MAX:  cfg_q.reg_count_max  <= pwdata[15:0];
				REG_COIL_MIN: cfg_q.coil_count_min <= pwdata[15:0];
				REG_COIL_MAX: cfg_q.coil_count_max <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OWN_ADDR: prdata = {24'h000000, cfg_q.own_address};
			REG_REG_MIN:  prdata = {16'h0000, cfg_q.reg_count_min};
			REG_REG_MAX:  prdata = {16'h0000, cfg_q.reg_count_max};
			REG_COIL_MIN: prdata = {16'h0000, cfg_q.coil_count_min};
			REG_COIL_MAX: prdata = {16'h0000, cfg_q.coil_count_max};
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* sv/rtuchk_accum.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtuchk_accum (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [rtuchk_pkg::IN_DW-1:0] s_tdata,
	input  wire logic                      s_tlast,
	input  wire logic                      pop,
	output logic                           frame_valid,
	output rtuchk_pkg::frame_t             frame
);
	import rtuchk_pkg::*;

	logic [15:0]               crc_q;
	logic [COUNT_W-1:0]        count_q;
	logic [HDR_BYTES-1:0][7:0] hdr_q;
	logic                      valid_s1;
	frame_t                    frame_s1;

	logic                      accept;
	frame_t                    nxt;

	assign s_tready    = !valid_s1 || pop;
	assign accept      = s_tvalid && s_tready;
	assign frame_valid = valid_s1;
	assign frame       = frame_s1;

	always_comb begin
		nxt.crc   = crc_byte(crc_q, s_tdata);
		nxt.count = (count_q == COUNT_SAT) ? count_q : count_q + 9'd1;
		nxt.hdr   = hdr_q;
		if (count_q < 9'(HDR_BYTES)) begin
			nxt.hdr[count_q[HDR_IDX_W-1:0]] = s_tdata;
		end
	end

	// running frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			count_q <= '0;
			hdr_q   <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				crc_q   <= CRC_INIT;
				count_q <= '0;
				hdr_q   <= '0;
			end else begin
				crc_q   <= nxt.crc;
				count_q <= nxt.count;
				hdr_q   <= nxt.hdr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= accept && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			frame_s1 <= nxt;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tlast |=> crc_q == CRC_INIT && count_q == '0 && hdr_q == '0)
		else $error("frame state not cleared after last byte");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !pop |=> valid_s1 && $stable(frame_s1))
		else $error("pending frame lost or changed");

	a_s1_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> frame_s1.count != '0)
		else $error("finished frame with zero bytes");

endmodule
`default_nettype wire

/* sv/rtuchk_check.sv */
`timescale 1ns / 1ps
`default_nettype none
module rtuchk_check #(
	parameter int MAX_FRAME = rtuchk_pkg::MAX_FRAME_DEF,
	parameter int MIN_FRAME = rtuchk_pkg::MIN_FRAME_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  rtuchk_pkg::cfg_t                 cfg,
	input  wire logic                        frame_valid,
	input  rtuchk_pkg::frame_t               frame,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [rtuchk_pkg::OUT_DW-1:0]    m_tdata
);
	import rtuchk_pkg::*;

	localparam logic [COUNT_W-1:0] MIN_CNT = COUNT_W'(MIN_FRAME);
	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAME);

	res_t        res;
	res_t        res_q;
	logic        m_valid_q;
	logic [7:0]  sa;
	logic [7:0]  fc;
	logic [15:0] w23;
	logic [15:0] w45;
	logic [15:0] c1;
	logic [15:0] c2;

	assign sa  = frame.hdr[0];
	assign fc  = frame.hdr[1];
	assign w23 = {frame.hdr[2], frame.hdr[3]};
	assign w45 = {frame.hdr[4], frame.hdr[5]};

	always_comb begin
		res               = '0;
		res.slave_addr    = sa;
		res.function_code = fc;
		if (sa != cfg.own_address) begin
			res.outcome = OUT_NOT_ADDR;
		end else if (frame.count < MIN_CNT || frame.count > MAX_CNT || frame.crc != 16'h0000) begin
			res.outcome = OUT_BAD_FRAME;
		end else begin
			case (fc)
				FC_READ_COILS: begin
					res.data_addr  = w23;
					res.data_count = w45;
					if (w45 < cfg.coil_count_min || w45 > cfg.coil_count_max) begin
						res.outcome        = OUT_ILL_DATA;
						res.exception_code = EXC_ILL_DATA;
					end
				end
				FC_READ_REGS, FC_WRITE_REGS: begin
					res.data_addr  = w23;
					res.data_count = w45;
					if (w45 < cfg.reg_count_min || w45 > cfg.reg_count_max) begin
						res.outcome        = OUT_ILL_DATA;
						res.exception_code = EXC_ILL_DATA;
					end
				end
				FC_WRITE_COIL: begin
					res.data_addr   = w23;
					res.data_count  = 16'd1;
					res.write_value = w45;
					if (w45 != COIL_OFF && w45 != COIL_ON) begin
						res.outcome        = OUT_ILL_DATA;
						res.exception_code = EXC_ILL_DATA;
					end
				end
				FC_WRITE_REG: begin
					res.data_addr   = w23;
					res.data_count  = 16'd1;
					res.write_value = w45;
				end
				default: begin
					res.outcome        = OUT_ILL_FUNC;
					res.exception_code = EXC_ILL_FUNC;
				end
			endcase
		end
		if (res.exception_code != EXC_NONE) begin
			res.reply_crc = crc_byte(c2, {6'b000000, res.exception_code});
		end
	end

	// crc of the exception reply: address, flagged code, exception code
	assign c1 = crc_byte(CRC_INIT, sa);
	assign c2 = crc_byte(c1, fc + FC_EXC_FLAG);

	assign pop      = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pop) begin
			m_valid_q <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && frame_valid) begin
			res_q <= res;
		end
	end

	a_ok_no_exc: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.outcome == OUT_OK |->
		res_q.exception_code == EXC_NONE && res_q.reply_crc == 16'h0000)
		else $error("accepted request carries an exception");

	a_ill_func: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && res_q.outcome == OUT_ILL_FUNC |->
		res_q.exception_code == EXC_ILL_FUNC && res_q.data_addr == 16'h0000)
		else $error("illegal function verdict inconsistent");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (res_q.outcome == OUT_NOT_ADDR || res_q.outcome == OUT_BAD_FRAME) |->
		res_q.data_count == 16'h0000 && res_q.exception_code == EXC_NONE)
		else $error("rejected frame carries decoded fields");

endmodule
`default_nettype wire

/* bench/rtu_verdict_checker.sv */
`timescale 1ns / 1ps
package rtu_bench_pkg;

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ data[k]) begin
				r = {1'b0, r[15:1]} ^ rtuchk_pkg::CRC_POLY;
			end else begin
				r = {1'b0, r[15:1]};
			end
		end
		return r;
	endfunction

endpackage

module rtu_verdict_checker
	import rtuchk_pkg::*;
	import rtu_bench_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [IN_DW-1:0]  s_tdata,
	input  wire logic              s_tlast,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [OUT_DW-1:0] m_tdata,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	input  wire logic [APB_DW-1:0] prdata,
	input  wire logic              pready,
	output int                     mismatches,
	output int                     verdicts_pending,
	output int                     frames_checked,
	output int                     requests_accepted,
	output int                     exceptions_seen
);

	typedef struct packed {
		logic [2:0]  outcome;
		logic [7:0]  slave_addr;
		logic [7:0]  function_code;
		logic [15:0] data_addr;
		logic [15:0] data_count;
		logic [15:0] write_value;
		logic [1:0]  exception_code;
		logic [15:0] reply_crc;
	} verdict_t;

	verdict_t pending_verdicts [$];

	logic [7:0]         own_addr;
	logic [15:0]        reg_min;
	logic [15:0]        reg_max;
	logic [15:0]        coil_min;
	logic [15:0]        coil_max;
	logic [15:0]        crc_run;
	logic [COUNT_W-1:0] nbytes;
	logic [7:0]         hdr [HDR_BYTES];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40) begin
			$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		end
		mismatches++;
	endtask

	function automatic verdict_t judge_frame();
		verdict_t v;
		logic [15:0] w23;
		logic [15:0] w45;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] c;
		v = '0;
		w23 = {hdr[2], hdr[3]};
		w45 = {hdr[4], hdr[5]};
		v.slave_addr = hdr[0];
		v.function_code = hdr[1];
		v.outcome = OUT_OK;
		if (hdr[0] != own_addr) begin
			v.outcome = OUT_NOT_ADDR;
		end else if (nbytes < MIN_FRAME_DEF || nbytes > MAX_FRAME_DEF || crc_run != 16'h0000) begin
			v.outcome = OUT_BAD_FRAME;
		end else begin
			case (hdr[1])
			FC_READ_COILS, FC_READ_REGS, FC_WRITE_REGS: begin
				lo = (hdr[1] == FC_READ_COILS) ? coil_min : reg_min;
				hi = (hdr[1] == FC_READ_COILS) ? coil_max : reg_max;
				v.data_addr = w23;
				v.data_count = w45;
				if (w45 < lo || w45 > hi) v.exception_code = EXC_ILL_DATA;
			end
			FC_WRITE_COIL, FC_WRITE_REG: begin
				v.data_addr = w23;
				v.data_count = 16'd1;
				v.write_value = w45;
				if (hdr[1] == FC_WRITE_COIL && w45 != COIL_OFF && w45 != COIL_ON) begin
					v.exception_code = EXC_ILL_DATA;
				end
			end
			default: begin
				v.exception_code = EXC_ILL_FUNC;
			end
			endcase
			if (v.exception_code == EXC_ILL_DATA) v.outcome = OUT_ILL_DATA;
			if (v.exception_code == EXC_ILL_FUNC) v.outcome = OUT_ILL_FUNC;
			if (v.exception_code != EXC_NONE) begin
				c = crc16_step(CRC_INIT, hdr[0]);
				c = crc16_step(c, hdr[1] + FC_EXC_FLAG);
				c = crc16_step(c, {6'd0, v.exception_code});
				v.reply_crc = c;
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		logic [31:0] held;
		if (!arst_n) begin
			own_addr = DEF_OWN_ADDR;
			reg_min = DEF_REG_MIN;
			reg_max = DEF_REG_MAX;
			coil_min = DEF_COIL_MIN;
			coil_max = DEF_COIL_MAX;
			crc_run = CRC_INIT;
			nbytes = '0;
			foreach (hdr[k]) hdr[k] = 8'h00;
			pending_verdicts.delete();
			mismatches = 0;
			verdicts_pending = 0;
			frames_checked = 0;
			requests_accepted = 0;
			exceptions_seen = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[4:2])
					REG_OWN_ADDR: own_addr = pwdata[7:0];
					REG_REG_MIN:  reg_min = pwdata[15:0];
					REG_REG_MAX:  reg_max = pwdata[15:0];
					REG_COIL_MIN: coil_min = pwdata[15:0];
					REG_COIL_MAX: coil_max = pwdata[15:0];
					default: ;
					endcase
				end else if (paddr[4:2] <= REG_COIL_MAX) begin
					case (paddr[4:2])
					REG_OWN_ADDR: held = {24'd0, own_addr};
					REG_REG_MIN:  held = {16'd0, reg_min};
					REG_REG_MAX:  held = {16'd0, reg_max};
					REG_COIL_MIN: held = {16'd0, coil_min};
					default:      held = {16'd0, coil_max};
					endcase
					if (prdata != held) report_mismatch("register read", prdata, held);
				end
			end

			if (m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("verdict with no request waiting", m_tdata[2:0], 0);
				end else begin
					want = pending_verdicts.pop_front();
					frames_checked++;
					if (want.outcome == OUT_OK) requests_accepted++;
					if (want.exception_code != EXC_NONE) exceptions_seen++;
					if (m_tdata[2:0] != want.outcome)
						report_mismatch("outcome", m_tdata[2:0], want.outcome);
					if (m_tdata[10:3] != want.slave_addr)
						report_mismatch("slave_addr", m_tdata[10:3], want.slave_addr);
					if (m_tdata[18:11] != want.function_code)
						report_mismatch("function_code", m_tdata[18:11], want.function_code);
					if (m_tdata[34:19] != want.data_addr)
						report_mismatch("data_addr", m_tdata[34:19], want.data_addr);
					if (m_tdata[50:35] != want.data_count)
						report_mismatch("data_count", m_tdata[50:35], want.data_count);
					if (m_tdata[66:51] != want.write_value)
						report_mismatch("write_value", m_tdata[66:51], want.write_value);
					if (m_tdata[68:67] != want.exception_code)
						report_mismatch("exception_code", m_tdata[68:67], want.exception_code);
					if (m_tdata[84:69] != want.reply_crc)
						report_mismatch("reply_crc", m_tdata[84:69], want.reply_crc);
					if (m_tdata[87:85] != 3'd0)
						report_mismatch("padding", m_tdata[87:85], 0);
				end
			end

			if (s_tvalid && s_tready) begin
				crc_run = crc16_step(crc_run, s_tdata);
				if (nbytes < HDR_BYTES) hdr[nbytes] = s_tdata;
				if (nbytes != COUNT_SAT) nbytes = nbytes + 1'b1;
				if (s_tlast) begin
					pending_verdicts.push_back(judge_frame());
					crc_run = CRC_INIT;
					nbytes = '0;
					foreach (hdr[k]) hdr[k] = 8'h00;
				end
			end

			verdicts_pending = pending_verdicts.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import rtuchk_pkg::*;
	import rtu_bench_pkg::*;

	typedef enum {KEEP_CRC, FLIP_CRC, TRUNCATE} damage_t;
	typedef enum {RX_ALWAYS, RX_LIKELY, RX_PERIODIC, RX_COIN} rx_mode_t;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int mismatches;
	int verdicts_pending;
	int frames_checked;
	int requests_accepted;
	int exceptions_seen;

	int       cycles = 0;
	int       burst_left = 0;
	int       bytes_sent = 0;
	int       settings_used = 1;
	rx_mode_t rx_mode = RX_ALWAYS;

	logic [7:0]  cfg_own = DEF_OWN_ADDR;
	logic [15:0] cfg_rmin = DEF_REG_MIN;
	logic [15:0] cfg_rmax = DEF_REG_MAX;
	logic [15:0] cfg_cmin = DEF_COIL_MIN;
	logic [15:0] cfg_cmax = DEF_COIL_MAX;

	modbus_rtu_slave_request_checker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rtu_verdict_checker verdict_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.mismatches        (mismatches),
		.verdicts_pending  (verdicts_pending),
		.frames_checked    (frames_checked),
		.requests_accepted (requests_accepted),
		.exceptions_seen   (exceptions_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// response side stall pattern and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 400 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
		RX_ALWAYS:   m_tready <= 1'b1;
		RX_LIKELY:   m_tready <= ($urandom_range(0, 3) != 0);
		RX_PERIODIC: m_tready <= ((cycles % 23) > 15);
		default:     m_tready <= 1'($urandom_range(0, 1));
		endcase
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				burst_left = $urandom_range(1, 24);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_junk(input int len, input logic [7:0] first);
		send_byte(first, len == 1);
		for (int k = 1; k < len; k++) send_byte(8'($urandom_range(0, 255)), k == len - 1);
	endtask

	task automatic send_frame(input logic [7:0] sa, input logic [7:0] fc,
			input logic [15:0] w23, input logic [15:0] w45, input int head_len,
			input int extra, input damage_t damage);
		logic [7:0]  frame [$];
		logic [47:0] head;
		logic [15:0] crc;
		head = {sa, fc, w23, w45};
		for (int k = 0; k < head_len; k++) frame.push_back(head[47 - 8 * k -: 8]);
		repeat (extra) frame.push_back(8'($urandom_range(0, 255)));
		crc = CRC_INIT;
		foreach (frame[k]) crc = crc16_step(crc, frame[k]);
		if (damage == FLIP_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
		frame.push_back(crc[7:0]);
		frame.push_back(crc[15:8]);
		if (damage == TRUNCATE) begin
			repeat ($urandom_range(1, frame.size() - 1)) frame.delete(frame.size() - 1);
		end
		foreach (frame[k]) send_byte(frame[k], k == frame.size() - 1);
	endtask

	function automatic logic [15:0] near_limit(input logic [15:0] lo, input logic [15:0] hi);
		case ($urandom_range(0, 5))
		0: return lo;
		1: return hi;
		2: return lo - 16'd1;
		3: return hi + 16'd1;
		4: return 16'($urandom_range(0, 65535));
		default: return (lo <= hi) ? 16'($urandom_range(lo, hi)) : lo;
		endcase
	endfunction

	task automatic random_request();
		logic [7:0]  sa;
		logic [7:0]  fc;
		logic [15:0] w45;
		int          pick;
		int          head_len;
		int          extra;
		damage_t     damage;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			sa = ($urandom_range(0, 1) == 1) ? cfg_own : 8'($urandom_range(0, 255));
			send_junk($urandom_range(1, 12), sa);
		end else begin
			sa = ($urandom_range(0, 9) < 8) ? cfg_own : 8'($urandom_range(0, 255));
			case ($urandom_range(0, 6))
			0: fc = FC_READ_COILS;
			1: fc = FC_READ_REGS;
			2: fc = FC_WRITE_REGS;
			3: fc = FC_WRITE_COIL;
			4: fc = FC_WRITE_REG;
			5: fc = 8'($urandom_range(0, 255));
			default: fc = FC_READ_REGS;
			endcase
			case (fc)
			FC_READ_COILS: w45 = near_limit(cfg_cmin, cfg_cmax);
			FC_READ_REGS, FC_WRITE_REGS: w45 = near_limit(cfg_rmin, cfg_rmax);
			FC_WRITE_COIL: begin
				case ($urandom_range(0, 2))
				0: w45 = COIL_OFF;
				1: w45 = COIL_ON;
				default: w45 = 16'($urandom_range(0, 65535));
				endcase
			end
			default: w45 = 16'($urandom_range(0, 65535));
			endcase
			extra = (fc == FC_WRITE_REGS) ? $urandom_range(0, 9) : 0;
			head_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 5) : 6;
			if (pick < 14) begin
				damage = FLIP_CRC;
			end else if (pick < 20) begin
				damage = TRUNCATE;
			end else begin
				damage = KEEP_CRC;
			end
			send_frame(sa, fc, 16'($urandom_range(0, 65535)), w45, head_len, extra, damage);
		end
	endtask

	task automatic random_phase(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) random_request();
	endtask

	// sender holds off until every verdict is back
	task automatic drain_verdicts();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (verdicts_pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_access(input logic [2:0] idx, input logic write, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_back_config();
		for (int k = REG_OWN_ADDR; k <= REG_COIL_MAX; k++) apb_access(3'(k), 1'b0, '0);
	endtask

	task automatic set_config(input logic [7:0] own, input logic [15:0] rmin,
			input logic [15:0] rmax, input logic [15:0] cmin, input logic [15:0] cmax);
		cfg_own = own;
		cfg_rmin = rmin;
		cfg_rmax = rmax;
		cfg_cmin = cmin;
		cfg_cmax = cmax;
		apb_access(REG_OWN_ADDR, 1'b1, {24'd0, own});
		apb_access(REG_REG_MIN, 1'b1, {16'd0, rmin});
		apb_access(REG_REG_MAX, 1'b1, {16'd0, rmax});
		apb_access(REG_COIL_MIN, 1'b1, {16'd0, cmin});
		apb_access(REG_COIL_MAX, 1'b1, {16'd0, cmax});
		read_back_config();
		settings_used++;
	endtask

	initial begin
		logic [15:0] lo_r;
		logic [15:0] lo_c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// write past the register list must leave everything alone
		apb_access(REG_UNUSED, 1'b1, 32'hFFFF_FFFF);
		read_back_config();

		send_frame(DEF_OWN_ADDR, FC_READ_COILS, 16'h0000, 16'd1, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_COILS, 16'hFFFF, 16'd2000, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_COILS, 16'h0000, 16'd2001, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_COILS, 16'h0000, 16'd0, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_REGS, 16'h1234, 16'd125, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_REGS, 16'h0000, 16'd126, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REGS, 16'h0000, 16'd0, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REGS, 16'h00FF, 16'd2, 6, 5, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_COIL, 16'h0010, COIL_ON, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_COIL, 16'h0010, COIL_OFF, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_COIL, 16'h0010, 16'h00FF, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'hFFFF, 16'hFFFF, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, 8'h00, 16'h0001, 16'h0001, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, 8'hFF, 16'h0001, 16'h0001, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, 8'h02, 16'h0001, 16'h0001, 6, 0, KEEP_CRC);
		send_frame(8'h00, FC_READ_REGS, 16'h0000, 16'd1, 6, 0, KEEP_CRC);
		send_frame(8'hFF, FC_READ_REGS, 16'h0000, 16'd1, 6, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_REGS, 16'h0000, 16'd1, 6, 0, FLIP_CRC);
		send_frame(DEF_OWN_ADDR, FC_READ_REGS, 16'h0000, 16'd1, 6, 0, TRUNCATE);
		// shortest frames: one byte, four bytes, five bytes with a good check, and three bytes
		send_junk(1, DEF_OWN_ADDR);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'h0000, 16'h0000, 2, 0, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'hA500, 16'h0000, 3, 0, KEEP_CRC);
		send_junk(3, 8'h22);
		// longest legal frame, one byte over, and a count that saturates
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'h0001, 16'h0002, 6, 248, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'h0001, 16'h0002, 6, 249, KEEP_CRC);
		send_frame(DEF_OWN_ADDR, FC_WRITE_REG, 16'h0001, 16'h0002, 6, 510, KEEP_CRC);

		random_phase(30);

		drain_verdicts();
		set_config(8'd247, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
		random_phase(30);

		// min above max refuses every count
		drain_verdicts();
		set_config(8'h5A, 16'd100, 16'd50, 16'hFFFF, 16'd0);
		random_phase(30);

		drain_verdicts();
		lo_r = 16'($urandom_range(0, 200));
		lo_c = 16'($urandom_range(0, 200));
		set_config(8'($urandom_range(2, 246)), lo_r, lo_r + 16'($urandom_range(0, 300)),
			lo_c, lo_c + 16'($urandom_range(0, 300)));
		random_phase(30);

		drain_verdicts();
		set_config(8'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		random_phase(30);

		drain_verdicts();
		$display("checked %0d frames under %0d register settings (%0d bytes sent)",
			frames_checked, settings_used, bytes_sent);
		$display("%0d requests accepted, %0d exception replies",
			requests_accepted, exceptions_seen);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
sv/rtuchk_pkg.sv
sv/rtuchk_cfg_regs.sv
sv/rtuchk_accum.sv
sv/rtuchk_check.sv
sv/modbus_rtu_slave_request_checker_core.sv
bench/rtu_verdict_checker.sv
bench/testbench.sv
